// File: src/ppr_pkg.sv
package ppr_pkg;

  localparam int unsigned MSG_LEN = 64;
  localparam int unsigned CNT_W   = $clog2(MSG_LEN + 1);
  localparam int unsigned TMO_W   = 16;
  localparam logic [TMO_W-1:0] TMO_RESET = 16'd20000;

  // request codes on in_req_type
  localparam logic [1:0] REQ_BYTE  = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_LNRST = 2'd2;

  // segmentation codes, header bits 7..6
  localparam logic [1:0] SEG_COMPLETE = 2'd0;
  localparam logic [1:0] SEG_FIRST    = 2'd1;
  localparam logic [1:0] SEG_CONT     = 2'd2;
  localparam logic [1:0] SEG_LAST     = 2'd3;

  // status codes
  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_CPL_PEND    = 4'd1;
  localparam logic [3:0] ST_FIRST_PEND  = 4'd2;
  localparam logic [3:0] ST_CONT_EMPTY  = 4'd3;
  localparam logic [3:0] ST_CONT_TYPE   = 4'd4;
  localparam logic [3:0] ST_LAST_EMPTY  = 4'd5;
  localparam logic [3:0] ST_LAST_TYPE   = 4'd6;
  localparam logic [3:0] ST_OVERFLOW    = 4'd7;
  localparam logic [3:0] ST_TIMEOUT     = 4'd8;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_BYTE,
    KIND_TICK,
    KIND_LNRST
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic       hdr;
    logic       last;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic [5:0] pdu_type;
    logic       msg_last;
    logic [3:0] status;
    logic       disconnect;
  } res_t;

endpackage

// File: src/ppr_front.sv
module ppr_front
  import ppr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [1:0] in_req_type,
  input  logic [7:0] in_data_byte,
  input  logic       in_pdu_first,
  input  logic       in_pdu_last,
  output logic       cmd_valid,
  output cmd_t       cmd,
  input  logic       cmd_take
);

  cmd_t       q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       wr_en;
  logic       rd_en;
  cmd_t       cls;

  // classify the raw item before it is queued
  always_comb begin
    cls.hdr  = in_pdu_first;
    cls.last = in_pdu_last;
    cls.data = in_data_byte;
    case (in_req_type)
      REQ_BYTE:  cls.kind = KIND_BYTE;
      REQ_TICK:  cls.kind = KIND_TICK;
      REQ_LNRST: cls.kind = KIND_LNRST;
      default:   cls.kind = KIND_NONE;
    endcase
  end

  assign in_full   = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign wr_en     = in_push && !in_full;
  assign rd_en     = cmd_take && cmd_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (wr_en) wr_ptr_r <= !wr_ptr_r;
      if (rd_en) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: src/ppr_outq.sv
module ppr_outq
  import ppr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic res_push,
  input  res_t res,
  output logic res_full,
  output logic out_empty,
  input  logic out_pop,
  output res_t out_res
);

  res_t       q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       wr_en;
  logic       rd_en;

  assign res_full  = (cnt_r == 2'd2);
  assign out_empty = (cnt_r == 2'd0);
  assign out_res   = q_r[rd_ptr_r];
  assign wr_en     = res_push && !res_full;
  assign rd_en     = out_pop && !out_empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (wr_en) wr_ptr_r <= !wr_ptr_r;
      if (rd_en) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: src/ppr_back.sv
module ppr_back
  import ppr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [TMO_W-1:0] cfg_sar_timeout_ticks,
  input  logic             cmd_valid,
  input  cmd_t             cmd,
  output logic             cmd_take,
  output logic             res_push,
  output res_t             res,
  input  logic             res_full
);

  logic [TMO_W-1:0] tmo_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [5:0]       type_r, type_nxt;
  logic [1:0]       sar_r, sar_nxt;
  logic             rej_r, rej_nxt;
  logic [TMO_W-1:0] tmr_cnt_r, tmr_cnt_nxt;
  logic             tmr_run_r, tmr_run_nxt;
  logic             in_pdu_r, in_pdu_nxt;
  logic             fire;

  assign fire     = cmd_valid && !res_full;
  assign cmd_take = fire;
  assign res_push = fire;

  always_comb begin
    logic [1:0] sar;
    logic [5:0] typ;
    logic [3:0] st;
    logic       payload;

    sar         = cmd.data[7:6];
    typ         = cmd.data[5:0];
    st          = ST_OK;
    payload     = 1'b0;
    cnt_nxt     = cnt_r;
    type_nxt    = type_r;
    sar_nxt     = sar_r;
    rej_nxt     = rej_r;
    tmr_cnt_nxt = tmr_cnt_r;
    tmr_run_nxt = tmr_run_r;
    in_pdu_nxt  = in_pdu_r;
    res         = '0;

    case (cmd.kind)
      KIND_BYTE: begin
        if (cmd.hdr) begin
          case (sar)
            SEG_COMPLETE: begin
              if (cnt_r != '0) st = ST_CPL_PEND;
              else type_nxt = typ;
            end
            SEG_FIRST: begin
              if (cnt_r != '0) begin
                st = ST_FIRST_PEND;
              end else begin
                tmr_cnt_nxt = tmo_r;
                tmr_run_nxt = 1'b1;
                type_nxt    = typ;
              end
            end
            SEG_CONT: begin
              if (cnt_r == '0) begin
                st = ST_CONT_EMPTY;
              end else if (type_r != typ) begin
                st = ST_CONT_TYPE;
              end else begin
                tmr_cnt_nxt = tmo_r;
                tmr_run_nxt = 1'b1;
              end
            end
            default: begin
              if (cnt_r == '0) st = ST_LAST_EMPTY;
              else if (type_r != typ) st = ST_LAST_TYPE;
              else tmr_run_nxt = 1'b0;
            end
          endcase
          sar_nxt    = sar;
          rej_nxt    = (st != ST_OK);
          in_pdu_nxt = 1'b1;
        end else if (in_pdu_r) begin
          payload = 1'b1;
        end

        if (in_pdu_nxt && !rej_nxt) begin
          if (payload) begin
            if (cnt_r >= CNT_W'(MSG_LEN)) begin
              st = ST_OVERFLOW;
            end else begin
              res.valid = 1'b1;
              res.data  = cmd.data;
              cnt_nxt   = cnt_r + CNT_W'(1);
            end
          end
          if (cmd.last && (sar_nxt == SEG_COMPLETE || sar_nxt == SEG_LAST)) begin
            res.msg_last = 1'b1;
            cnt_nxt      = '0;
          end
        end
        if (in_pdu_nxt && cmd.last) begin
          in_pdu_nxt = 1'b0;
          rej_nxt    = 1'b0;
        end
      end
      KIND_TICK: begin
        if (tmr_run_r) begin
          // a timeout of zero behaves as one tick
          if (tmr_cnt_r <= TMO_W'(1)) begin
            tmr_cnt_nxt    = '0;
            tmr_run_nxt    = 1'b0;
            cnt_nxt        = '0;
            in_pdu_nxt     = 1'b0;
            rej_nxt        = 1'b0;
            st             = ST_TIMEOUT;
            res.disconnect = 1'b1;
          end else begin
            tmr_cnt_nxt = tmr_cnt_r - TMO_W'(1);
          end
        end
      end
      KIND_LNRST: begin
        cnt_nxt     = '0;
        type_nxt    = '0;
        sar_nxt     = SEG_COMPLETE;
        rej_nxt     = 1'b0;
        tmr_cnt_nxt = '0;
        tmr_run_nxt = 1'b0;
        in_pdu_nxt  = 1'b0;
      end
      default: begin
      end
    endcase

    res.status = st;
    // link reset reports all zero, type included
    res.pdu_type = (cmd.kind == KIND_LNRST) ? 6'd0 : type_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmo_r <= TMO_RESET;
    end else if (cfg_we) begin
      tmo_r <= cfg_sar_timeout_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      type_r    <= '0;
      sar_r     <= SEG_COMPLETE;
      rej_r     <= 1'b0;
      tmr_cnt_r <= '0;
      tmr_run_r <= 1'b0;
      in_pdu_r  <= 1'b0;
    end else if (fire) begin
      cnt_r     <= cnt_nxt;
      type_r    <= type_nxt;
      sar_r     <= sar_nxt;
      rej_r     <= rej_nxt;
      tmr_cnt_r <= tmr_cnt_nxt;
      tmr_run_r <= tmr_run_nxt;
      in_pdu_r  <= in_pdu_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MSG_LEN))
    else $error("stored count beyond message length");

  a_rej_in_pdu: assert property (@(posedge clk) disable iff (!rst_n)
    rej_r |-> in_pdu_r)
    else $error("rejected flag outside a PDU");

  a_disc_status: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.disconnect) |-> (res.status == ST_TIMEOUT && !res.valid && !tmr_run_nxt))
    else $error("disconnect without timeout status");

  a_lnrst_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && cmd.kind == KIND_LNRST) |=> (cnt_r == '0 && !in_pdu_r && !tmr_run_r))
    else $error("link reset left state behind");

endmodule

// File: src/proxy_pdu_reassembler_core.sv
// Proxy PDU reassembler, receive side. Items enter one per cycle while in_full is
// low, through a queue-style port (in_push/in_full), and every item gives exactly
// one result on the out_ side (out_empty/out_pop), in order. An item is registered
// in the front queue and its result in the result queue, where it can be popped;
// with out_pop held high the block sustains one item per clock. That rate is set
// by the back end updating its state in one step (header check, byte counter and
// timeout counter all resolve together). A two-entry queue sits between the
// classifying front end and the back end, and a two-entry result queue drives the
// outputs, so either side may stall without losing an item.
// cfg_sar_timeout_ticks is written with cfg_we and should only change while idle.
module proxy_pdu_reassembler_core
  import ppr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [TMO_W-1:0] cfg_sar_timeout_ticks,
  input  logic             in_push,
  output logic             in_full,
  input  logic [1:0]       in_req_type,
  input  logic [7:0]       in_data_byte,
  input  logic             in_pdu_first,
  input  logic             in_pdu_last,
  output logic             out_empty,
  input  logic             out_pop,
  output logic             out_valid,
  output logic [7:0]       out_byte,
  output logic [5:0]       out_msg_type,
  output logic             out_msg_last,
  output logic [3:0]       out_status,
  output logic             out_disconnect
);

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;
  logic res_push;
  logic res_full;
  res_t res;
  res_t out_res;

  ppr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_req_type  (in_req_type),
    .in_data_byte (in_data_byte),
    .in_pdu_first (in_pdu_first),
    .in_pdu_last  (in_pdu_last),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_take     (cmd_take)
  );

  ppr_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_sar_timeout_ticks (cfg_sar_timeout_ticks),
    .cmd_valid             (cmd_valid),
    .cmd                   (cmd),
    .cmd_take              (cmd_take),
    .res_push              (res_push),
    .res                   (res),
    .res_full              (res_full)
  );

  ppr_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_res   (out_res)
  );

  assign out_valid      = out_res.valid;
  assign out_byte       = out_res.data;
  assign out_msg_type   = out_res.pdu_type;
  assign out_msg_last   = out_res.msg_last;
  assign out_status     = out_res.status;
  assign out_disconnect = out_res.disconnect;

endmodule
